@@ sv/cpu6502_execute_unit_assert.svh @@
`ifndef CPU6502_EXECUTE_UNIT_ASSERT_SVH
`define CPU6502_EXECUTE_UNIT_ASSERT_SVH
// shared assertion macros
`define CEU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CEU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ sv/ceu_pkg.sv @@
package ceu_pkg;
    typedef struct packed {
        logic [6:0] op_select;
        logic [7:0] operand;
        logic [7:0] addr_high_in;
        logic       page_crossed;
    } t_in_word;

    typedef struct packed {
        logic [7:0] mem_data;
        logic       mem_write_valid;
        logic       branch_taken;
        logic [7:0] addr_high_out;
        logic [7:0] acc_out;
        logic [7:0] xreg_out;
        logic [7:0] yreg_out;
        logic [7:0] sp_out;
        logic [7:0] flags_out;
    } t_out_word;

    typedef enum logic [6:0] {
        OP_LDA = 7'd0,  OP_STA = 7'd1,  OP_LDX = 7'd2,  OP_STX = 7'd3,
        OP_LDY = 7'd4,  OP_STY = 7'd5,  OP_TAX = 7'd6,  OP_TXA = 7'd7,
        OP_TAY = 7'd8,  OP_TYA = 7'd9,  OP_ADC = 7'd10, OP_SBC = 7'd11,
        OP_INC = 7'd12, OP_DEC = 7'd13, OP_INX = 7'd14, OP_DEX = 7'd15,
        OP_INY = 7'd16, OP_DEY = 7'd17, OP_ASL = 7'd18, OP_LSR = 7'd19,
        OP_ROL = 7'd20, OP_ROR = 7'd21, OP_AND = 7'd22, OP_ORA = 7'd23,
        OP_EOR = 7'd24, OP_BIT = 7'd25, OP_CMP = 7'd26, OP_CPX = 7'd27,
        OP_CPY = 7'd28, OP_BCC = 7'd29, OP_BCS = 7'd30, OP_BEQ = 7'd31,
        OP_BNE = 7'd32, OP_BPL = 7'd33, OP_BMI = 7'd34, OP_BVC = 7'd35,
        OP_BVS = 7'd36, OP_PHA = 7'd37, OP_PLA = 7'd38, OP_PHP = 7'd39,
        OP_PLP = 7'd40, OP_TXS = 7'd41, OP_TSX = 7'd42, OP_CLC = 7'd43,
        OP_SEC = 7'd44, OP_CLI = 7'd45, OP_SEI = 7'd46, OP_CLD = 7'd47,
        OP_SED = 7'd48, OP_CLV = 7'd49, OP_NOP = 7'd50, OP_SLO = 7'd51,
        OP_RLA = 7'd52, OP_SRE = 7'd53, OP_RRA = 7'd54, OP_SAX = 7'd55,
        OP_LAX = 7'd56, OP_DCP = 7'd57, OP_ISC = 7'd58, OP_SHA = 7'd59,
        OP_SHS = 7'd60, OP_SHY = 7'd61, OP_SHX = 7'd62, OP_LAS = 7'd63,
        OP_ANC = 7'd64, OP_ASR = 7'd65, OP_ARR = 7'd66, OP_ANE = 7'd67,
        OP_LXA = 7'd68, OP_AXS = 7'd69
    } t_op;

    localparam int unsigned FL_C = 0;
    localparam int unsigned FL_Z = 1;
    localparam int unsigned FL_I = 2;
    localparam int unsigned FL_D = 3;
    localparam int unsigned FL_B = 4;
    localparam int unsigned FL_U = 5;
    localparam int unsigned FL_V = 6;
    localparam int unsigned FL_N = 7;

    localparam logic [7:0] SP_RESET    = 8'hFD;
    localparam logic [7:0] P_RESET     = 8'h24;
    localparam logic [7:0] ANE_MAGIC   = 8'hEE;
    localparam logic [7:0] LXA_MAGIC   = 8'hFF;
endpackage

@@ sv/cpu6502_execute_unit.sv @@
// 6502-style execute unit, no decimal mode. One word in, one word out:
// every accepted word produces exactly one result word carrying the store
// byte, branch decision, address high byte after the SHx page-cross glitch
// and the updated A, X, Y, S and P. The architectural registers update at
// the edge a word is accepted, so words may issue back to back, one per
// cycle; the result is held in an output register and appears the cycle
// after acceptance. The input side is stalled only while a finished result
// is held under output stall and the next word could not be placed.
// After reset A=X=Y=0, S=0xFD, P=0x24.
module cpu6502_execute_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  ceu_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output ceu_pkg::t_out_word o_data
);
    import ceu_pkg::*;
    `include "cpu6502_execute_unit_assert.svh"

    // architectural state
    logic [7:0] r_a, r_x, r_y, r_s, r_p;
    logic [7:0] n_a, n_x, n_y, n_s, n_p;

    // output register
    logic       r_ovalid;
    t_out_word  r_out;
    t_out_word  n_out;

    logic accept;
    // input accepted whenever the output slot is free or drains this cycle
    assign o_stall = r_ovalid && i_stall;
    assign accept  = i_valid && !o_stall;

    // combinational execute
    always_comb begin
        logic [7:0] m, hi, h, d, v, sh;
        logic [8:0] sum, add_m;
        logic       c, addflag, use_add;
        logic [8:0] cmp_d;
        logic [7:0] cmp_r, cmp_m;
        logic       do_cmp, zn_en;
        logic [7:0] zn_v;
        m     = i_data.operand;
        hi    = i_data.addr_high_in;
        h     = i_data.page_crossed ? hi : hi + 8'd1;
        c     = r_p[FL_C];
        n_a = r_a; n_x = r_x; n_y = r_y; n_s = r_s; n_p = r_p;
        d = 8'd0; v = 8'd0; sh = 8'd0;
        n_out = '0;
        n_out.addr_high_out = hi;
        use_add = 1'b0; add_m = 9'd0; addflag = 1'b0;
        do_cmp = 1'b0; cmp_r = 8'd0; cmp_m = 8'd0;
        zn_en = 1'b0; zn_v = 8'd0;
        sum = 9'd0; cmp_d = 9'd0;
        unique case (i_data.op_select) inside
            OP_LDA: begin n_a = m; zn_en = 1'b1; zn_v = m; end
            OP_STA: begin d = r_a; n_out.mem_write_valid = 1'b1; end
            OP_LDX: begin n_x = m; zn_en = 1'b1; zn_v = m; end
            OP_STX: begin d = r_x; n_out.mem_write_valid = 1'b1; end
            OP_LDY: begin n_y = m; zn_en = 1'b1; zn_v = m; end
            OP_STY: begin d = r_y; n_out.mem_write_valid = 1'b1; end
            OP_TAX: begin n_x = r_a; zn_en = 1'b1; zn_v = r_a; end
            OP_TXA: begin n_a = r_x; zn_en = 1'b1; zn_v = r_x; end
            OP_TAY: begin n_y = r_a; zn_en = 1'b1; zn_v = r_a; end
            OP_TYA: begin n_a = r_y; zn_en = 1'b1; zn_v = r_y; end
            OP_ADC: begin use_add = 1'b1; add_m = {1'b0, m}; end
            OP_SBC: begin use_add = 1'b1; add_m = {1'b0, ~m}; end
            OP_INC: begin
                d = m + 8'd1; n_out.mem_write_valid = 1'b1; zn_en = 1'b1; zn_v = d;
            end
            OP_DEC: begin
                d = m - 8'd1; n_out.mem_write_valid = 1'b1; zn_en = 1'b1; zn_v = d;
            end
            OP_INX: begin n_x = r_x + 8'd1; zn_en = 1'b1; zn_v = n_x; end
            OP_DEX: begin n_x = r_x - 8'd1; zn_en = 1'b1; zn_v = n_x; end
            OP_INY: begin n_y = r_y + 8'd1; zn_en = 1'b1; zn_v = n_y; end
            OP_DEY: begin n_y = r_y - 8'd1; zn_en = 1'b1; zn_v = n_y; end
            OP_ASL, OP_ROL, OP_SLO, OP_RLA: begin
                addflag = (i_data.op_select == OP_ROL || i_data.op_select == OP_RLA)
                    ? c : 1'b0;
                d = {m[6:0], addflag};
                n_p[FL_C] = m[7];
                n_out.mem_write_valid = 1'b1;
                zn_en = 1'b1; zn_v = d;
                if (i_data.op_select == OP_SLO) begin
                    n_a = r_a | d; zn_v = n_a;
                end else if (i_data.op_select == OP_RLA) begin
                    n_a = r_a & d; zn_v = n_a;
                end
            end
            OP_LSR, OP_ROR, OP_SRE, OP_RRA: begin
                addflag = (i_data.op_select == OP_ROR || i_data.op_select == OP_RRA)
                    ? c : 1'b0;
                d = {addflag, m[7:1]};
                n_p[FL_C] = m[0];
                n_out.mem_write_valid = 1'b1;
                zn_en = 1'b1; zn_v = d;
                if (i_data.op_select == OP_SRE) begin
                    n_a = r_a ^ d; zn_v = n_a;
                end else if (i_data.op_select == OP_RRA) begin
                    zn_en = 1'b0; use_add = 1'b1; add_m = {1'b0, d};
                end
            end
            OP_AND: begin n_a = r_a & m; zn_en = 1'b1; zn_v = n_a; end
            OP_ORA: begin n_a = r_a | m; zn_en = 1'b1; zn_v = n_a; end
            OP_EOR: begin n_a = r_a ^ m; zn_en = 1'b1; zn_v = n_a; end
            OP_BIT: begin
                n_p[FL_V] = m[6]; n_p[FL_N] = m[7]; n_p[FL_Z] = ((m & r_a) == 8'd0);
            end
            OP_CMP: begin do_cmp = 1'b1; cmp_r = r_a; cmp_m = m; end
            OP_CPX: begin do_cmp = 1'b1; cmp_r = r_x; cmp_m = m; end
            OP_CPY: begin do_cmp = 1'b1; cmp_r = r_y; cmp_m = m; end
            OP_BCC: n_out.branch_taken = !r_p[FL_C];
            OP_BCS: n_out.branch_taken = r_p[FL_C];
            OP_BEQ: n_out.branch_taken = r_p[FL_Z];
            OP_BNE: n_out.branch_taken = !r_p[FL_Z];
            OP_BPL: n_out.branch_taken = !r_p[FL_N];
            OP_BMI: n_out.branch_taken = r_p[FL_N];
            OP_BVC: n_out.branch_taken = !r_p[FL_V];
            OP_BVS: n_out.branch_taken = r_p[FL_V];
            OP_PHA: begin d = r_a; n_out.mem_write_valid = 1'b1; n_s = r_s - 8'd1; end
            OP_PLA: begin n_s = r_s + 8'd1; n_a = m; zn_en = 1'b1; zn_v = m; end
            OP_PHP: begin
                d = r_p; d[FL_B] = 1'b1; d[FL_U] = 1'b1;
                n_out.mem_write_valid = 1'b1;
                n_p[FL_U] = 1'b1; n_p[FL_B] = 1'b0;
                n_s = r_s - 8'd1;
            end
            OP_PLP: begin
                n_s = r_s + 8'd1;
                n_p = (m & 8'hCF) | (r_p & 8'h30);
            end
            OP_TXS: n_s = r_x;
            OP_TSX: begin n_x = r_s; zn_en = 1'b1; zn_v = r_s; end
            OP_CLC: n_p[FL_C] = 1'b0;
            OP_SEC: n_p[FL_C] = 1'b1;
            OP_CLI: n_p[FL_I] = 1'b0;
            OP_SEI: n_p[FL_I] = 1'b1;
            OP_CLD: n_p[FL_D] = 1'b0;
            OP_SED: n_p[FL_D] = 1'b1;
            OP_CLV: n_p[FL_V] = 1'b0;
            OP_SAX: begin d = r_a & r_x; n_out.mem_write_valid = 1'b1; end
            OP_LAX: begin n_a = m; n_x = m; zn_en = 1'b1; zn_v = m; end
            OP_DCP: begin
                d = m - 8'd1; n_out.mem_write_valid = 1'b1;
                do_cmp = 1'b1; cmp_r = r_a; cmp_m = d;
            end
            OP_ISC: begin
                d = m + 8'd1; n_out.mem_write_valid = 1'b1;
                use_add = 1'b1; add_m = {1'b0, ~d};
            end
            OP_SHA, OP_SHS, OP_SHY, OP_SHX: begin
                case (i_data.op_select)
                    OP_SHY:  sh = r_y;
                    OP_SHX:  sh = r_x;
                    default: sh = r_a & r_x;
                endcase
                if (i_data.op_select == OP_SHS) n_s = r_a & r_x;
                d = sh & h;
                n_out.mem_write_valid = 1'b1;
                if (i_data.page_crossed) n_out.addr_high_out = d;
            end
            OP_LAS: begin
                v = m & r_s; n_a = v; n_x = v; n_s = v; zn_en = 1'b1; zn_v = v;
            end
            OP_ANC: begin
                v = r_a & m; n_a = v; n_p[FL_C] = v[7]; zn_en = 1'b1; zn_v = v;
            end
            OP_ASR: begin
                v = r_a & m; n_p[FL_C] = v[0]; n_a = {1'b0, v[7:1]};
                zn_en = 1'b1; zn_v = n_a;
            end
            OP_ARR: begin
                v = r_a & m; v = {c, v[7:1]};
                n_p[FL_C] = v[6]; n_p[FL_V] = v[6] ^ v[5];
                n_a = v; zn_en = 1'b1; zn_v = v;
            end
            OP_ANE: begin
                v = (r_a | ANE_MAGIC) & r_x & m; n_a = v; zn_en = 1'b1; zn_v = v;
            end
            OP_LXA: begin
                v = (r_a | LXA_MAGIC) & m; n_a = v; n_x = v; zn_en = 1'b1; zn_v = v;
            end
            OP_AXS: begin
                v = r_a & r_x; n_p[FL_C] = (v >= m);
                n_x = v - m; zn_en = 1'b1; zn_v = n_x;
            end
            default: ;
        endcase
        // shared adder for adc, sbc, rra, isc (carry seen after any rotate)
        if (use_add) begin
            sum = {1'b0, r_a} + add_m + {8'd0, n_p[FL_C]};
            n_p[FL_C] = sum[8];
            n_p[FL_V] = (sum[7] ^ r_a[7]) & (sum[7] ^ add_m[7]);
            n_a = sum[7:0];
            zn_en = 1'b1; zn_v = sum[7:0];
        end
        // shared comparator
        if (do_cmp) begin
            cmp_d = {1'b0, cmp_r} - {1'b0, cmp_m};
            n_p[FL_C] = !cmp_d[8];
            n_p[FL_Z] = (cmp_r == cmp_m);
            n_p[FL_N] = cmp_d[7];
        end
        if (zn_en) begin
            n_p[FL_Z] = (zn_v == 8'd0);
            n_p[FL_N] = zn_v[7];
        end
        n_out.mem_data  = d;
        n_out.acc_out   = n_a;
        n_out.xreg_out  = n_x;
        n_out.yreg_out  = n_y;
        n_out.sp_out    = n_s;
        n_out.flags_out = n_p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= 8'd0; r_x <= 8'd0; r_y <= 8'd0;
            r_s <= SP_RESET; r_p <= P_RESET;
            r_ovalid <= 1'b0;
        end else begin
            if (accept) begin
                r_a <= n_a; r_x <= n_x; r_y <= n_y; r_s <= n_s; r_p <= n_p;
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_out <= n_out;
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    // result mirrors the architectural registers
    `CEU_ASSERT_IMPL(a_acc_match, i_clk, i_rst_n, r_ovalid, r_out.acc_out == r_a)
    // no write means zero store byte
    `CEU_ASSERT_IMPL(a_nowr_zero, i_clk, i_rst_n, r_ovalid && !r_out.mem_write_valid, r_out.mem_data == 8'd0)
    // accepted word always yields a result next cycle
    `CEU_ASSERT_NEXT(a_accept_out, i_clk, i_rst_n, accept, r_ovalid)
endmodule
